// ===== sv/rlpwm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlpwm_pkg
// Shared types and constants for the RGB LED PWM slot encoder.
// ----------------------------------------------------------------------------
package rlpwm_pkg;

    // latch gap length after the last LED of a frame (0..64)
    localparam int GapSlots   = 40;
    localparam int GapCntW    = 6;
    localparam int SlotsPerLed = 24;

    // configuration register indexes
    localparam logic [1:0] CfgOutputEnable = 2'd0;
    localparam logic [1:0] CfgBrightness   = 2'd1;
    localparam logic [1:0] CfgOneDuty      = 2'd2;
    localparam logic [1:0] CfgZeroDuty     = 2'd3;

    localparam logic [6:0]  BrightMax       = 7'd100;
    localparam logic [15:0] OneDutyReset    = 16'd60;
    localparam logic [15:0] ZeroDutyReset   = 16'd30;

    // floor(x / 100) == (x * 5243) >> 19 for x <= 25500
    localparam logic [12:0] Recip100   = 13'd5243;
    localparam int          RecipShift = 19;

    typedef struct packed {
        logic [23:0] led_color;
        logic        final_led;
    } in_word_t;

    typedef struct packed {
        logic [15:0] duty_value;
        logic        in_trailer;
        logic        run_end;
    } out_word_t;

    typedef struct packed {
        logic        output_enable;
        logic [6:0]  bright_pct;
        logic [15:0] one_bit_duty;
        logic [15:0] zero_bit_duty;
    } cfg_t;

    // handoff from the scaler to the slot generator
    typedef struct packed {
        logic        start;
        logic [23:0] color;
        logic        final_led;
    } slot_cmd_t;

endpackage : rlpwm_pkg
`default_nettype wire

// ===== sv/rgb_led_pwm_slot_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_led_pwm_slot_encoder
// Turns one packed RGB color per LED into a stream of PWM duty slots.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per LED, the 24-bit color plus a final_led flag.
//   m_ channel: one duty slot per word, MSB of red first, 24 per LED; a
//     word flagged final_led adds 40 zero-duty gap slots (in_trailer = 1).
//     run_end marks the last slot caused by an input word.
//   cfg_ port: write-only registers, taken on any cycle with cfg_we high.
//     Write only while idle (s_ready high, all slots delivered).
// Throughput:
//   The shared multiplier scales the three channels in turn, then the slot
//   generator loads the scaled color. Slots then leave one per cycle when
//   m_ready stays high. s_ready is low from acceptance until the last slot
//   of that word is taken.
// Reset: aresetn low clears the sequencers and output valid; registers
//   return to output disabled, brightness 0, duties 60 and 30.
// Stall: m_ready low holds the current slot and pauses the slot sequencer.
// ----------------------------------------------------------------------------
module rgb_led_pwm_slot_encoder (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire rlpwm_pkg::in_word_t   s_word,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output rlpwm_pkg::out_word_t       m_word,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [15:0]           cfg_wdata
);

    rlpwm_pkg::cfg_t       cfg_reg;
    rlpwm_pkg::slot_cmd_t  cmd;
    rlpwm_pkg::out_word_t  out_word;
    logic                  out_valid;
    logic                  busy_reg, busy_next;
    logic                  accept;

    // configuration registers, brightness saturates at 100
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.output_enable      <= 1'b0;
            cfg_reg.bright_pct         <= 7'd0;
            cfg_reg.one_bit_duty       <= rlpwm_pkg::OneDutyReset;
            cfg_reg.zero_bit_duty      <= rlpwm_pkg::ZeroDutyReset;
        end else if (cfg_we) begin
            case (cfg_index)
                rlpwm_pkg::CfgOutputEnable: cfg_reg.output_enable <= cfg_wdata[0];
                rlpwm_pkg::CfgBrightness: begin
                    cfg_reg.bright_pct <=
                        (cfg_wdata[6:0] > rlpwm_pkg::BrightMax) ? rlpwm_pkg::BrightMax
                                                                : cfg_wdata[6:0];
                end
                rlpwm_pkg::CfgOneDuty:  cfg_reg.one_bit_duty  <= cfg_wdata;
                rlpwm_pkg::CfgZeroDuty: cfg_reg.zero_bit_duty <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // one LED word in flight at a time
    assign accept = s_valid && !busy_reg;

    always_comb begin
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (out_valid && m_ready && out_word.run_end) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    rlpwm_scaler u_scaler (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .color     (s_word.led_color),
        .final_led (s_word.final_led),
        .cfg       (cfg_reg),
        .cmd       (cmd)
    );

    rlpwm_slot_gen u_slot_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .cfg     (cfg_reg),
        .m_word  (out_word),
        .m_valid (out_valid),
        .m_ready (m_ready)
    );

    assign s_ready = !busy_reg;
    assign m_word  = out_word;
    assign m_valid = out_valid;

endmodule : rgb_led_pwm_slot_encoder
`default_nettype wire

// ===== sv/rlpwm_scaler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlpwm_scaler
// Scales the three color channels by brightness percent / 100 with one
// shared multiplier: even steps form ch * brightness, odd steps divide by
// 100 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module rlpwm_scaler (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [23:0]          color,
    input  wire logic                 final_led,
    input  wire rlpwm_pkg::cfg_t      cfg,
    output rlpwm_pkg::slot_cmd_t      cmd
);

    logic [2:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [23:0] src_reg, src_next;
    logic [23:0] res_reg, res_next;
    logic [14:0] prod_reg, prod_next;
    logic        final_reg, final_next;
    logic        done_reg, done_next;

    logic [14:0] op_a;
    logic [12:0] op_b;
    logic [27:0] mul;
    logic [7:0]  quot;

    // shared multiplier with operand selection
    always_comb begin
        if (!step_reg[0]) begin
            op_a = {7'd0, src_reg[23:16]};
            op_b = {6'd0, cfg.bright_pct};
        end else begin
            op_a = prod_reg;
            op_b = rlpwm_pkg::Recip100;
        end
        mul  = 28'(op_a) * 28'(op_b);
        quot = mul[rlpwm_pkg::RecipShift +: 8];
    end

    // sequencer
    always_comb begin
        step_next  = step_reg;
        busy_next  = busy_reg;
        src_next   = src_reg;
        res_next   = res_reg;
        prod_next  = prod_reg;
        final_next = final_reg;
        done_next  = 1'b0;
        if (!busy_reg) begin
            if (start) begin
                busy_next  = 1'b1;
                step_next  = 3'd0;
                src_next   = color;
                final_next = final_led;
            end
        end else if (!step_reg[0]) begin
            prod_next = mul[14:0];
            step_next = step_reg + 3'd1;
        end else begin
            // disabled output forces black
            res_next  = {res_reg[15:0], cfg.output_enable ? quot : 8'd0};
            src_next  = {src_reg[15:0], 8'd0};
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd5) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 3'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        src_reg   <= src_next;
        res_reg   <= res_next;
        prod_reg  <= prod_next;
        final_reg <= final_next;
    end

    assign cmd.start     = done_reg;
    assign cmd.color     = res_reg;
    assign cmd.final_led = final_reg;

endmodule : rlpwm_scaler
`default_nettype wire

// ===== sv/rlpwm_slot_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlpwm_slot_gen
// Shifts the scaled color out MSB first as 24 duty slots, then the latch
// gap when the LED closes a frame. Output word sits in a register.
// ----------------------------------------------------------------------------
module rlpwm_slot_gen (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire rlpwm_pkg::slot_cmd_t  cmd,
    input  wire rlpwm_pkg::cfg_t       cfg,
    output rlpwm_pkg::out_word_t       m_word,
    output logic                       m_valid,
    input  wire logic                  m_ready
);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StData = 2'd1;
    localparam logic [1:0] StGap  = 2'd2;

    localparam logic [4:0] BitLast = 5'(rlpwm_pkg::SlotsPerLed - 1);
    localparam logic [rlpwm_pkg::GapCntW-1:0] GapLast =
        rlpwm_pkg::GapCntW'((rlpwm_pkg::GapSlots == 0) ? 0 : rlpwm_pkg::GapSlots - 1);
    localparam logic GapOn = (rlpwm_pkg::GapSlots != 0);

    logic [1:0]                      state_reg, state_next;
    logic [23:0]                     shift_reg, shift_next;
    logic [4:0]                      bit_reg, bit_next;
    logic [rlpwm_pkg::GapCntW-1:0]   gap_reg, gap_next;
    logic                            gap_en_reg, gap_en_next;
    logic                            valid_reg, valid_next;
    rlpwm_pkg::out_word_t            word_reg, word_next;
    logic                            adv;

    // output register free or being emptied this cycle
    assign adv = !valid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        shift_next  = shift_reg;
        bit_next    = bit_reg;
        gap_next    = gap_reg;
        gap_en_next = gap_en_reg;
        valid_next  = valid_reg && !m_ready;
        word_next   = word_reg;
        case (state_reg)
            StIdle: begin
                if (cmd.start) begin
                    shift_next  = cmd.color;
                    bit_next    = 5'd0;
                    gap_en_next = cmd.final_led && GapOn;
                    state_next  = StData;
                end
            end
            StData: begin
                if (adv) begin
                    valid_next           = 1'b1;
                    word_next.duty_value = shift_reg[23] ? cfg.one_bit_duty
                                                         : cfg.zero_bit_duty;
                    word_next.in_trailer = 1'b0;
                    word_next.run_end    = (bit_reg == BitLast) && !gap_en_reg;
                    shift_next           = {shift_reg[22:0], 1'b0};
                    bit_next             = bit_reg + 5'd1;
                    if (bit_reg == BitLast) begin
                        gap_next   = '0;
                        state_next = gap_en_reg ? StGap : StIdle;
                    end
                end
            end
            StGap: begin
                if (adv) begin
                    valid_next           = 1'b1;
                    word_next.duty_value = 16'd0;
                    word_next.in_trailer = 1'b1;
                    word_next.run_end    = (gap_reg == GapLast);
                    gap_next             = gap_reg + rlpwm_pkg::GapCntW'(1);
                    if (gap_reg == GapLast) begin
                        state_next = StIdle;
                    end
                end
            end
            default: begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= StIdle;
            valid_reg <= 1'b0;
            bit_reg   <= 5'd0;
            gap_reg   <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            bit_reg   <= bit_next;
            gap_reg   <= gap_next;
        end
        shift_reg  <= shift_next;
        gap_en_reg <= gap_en_next;
        word_reg   <= word_next;
    end

    assign m_word  = word_reg;
    assign m_valid = valid_reg;

endmodule : rlpwm_slot_gen
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB LED PWM slot encoder.
// Drives LED colors through the valid/ready input, predicts every duty slot
// (brightness scaling, bit expansion MSB first, latch gap after the last LED)
// and checks each delivered slot in order. Registers are rewritten between
// phases while the encoder is idle; both sides stall at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int  ClkHalf     = 4;
    localparam int  SettleCyc   = 12;
    localparam int  LongHoldCyc = 300;
    localparam int  RandPhases  = 6;
    localparam int  LedsPerPh   = 32;
    localparam time TimeLimitNs = 5_000_000;

    // Expected slot store plus a shadow copy of the register file
    class slot_scoreboard;
        rlpwm_pkg::cfg_t      regs;
        rlpwm_pkg::out_word_t slots_due[$];
        int        errors;
        int        leds;
        int        frames;
        int        slots_ok;

        function new();
            regs.output_enable      = 1'b0;
            regs.bright_pct         = '0;
            regs.one_bit_duty       = rlpwm_pkg::OneDutyReset;
            regs.zero_bit_duty      = rlpwm_pkg::ZeroDutyReset;
            errors   = 0;
            leds     = 0;
            frames   = 0;
            slots_ok = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                rlpwm_pkg::CfgOutputEnable: regs.output_enable = data[0];
                rlpwm_pkg::CfgBrightness: begin
                    // only the low 7 bits are kept, then clipped to 100 percent
                    regs.bright_pct = (data[6:0] > rlpwm_pkg::BrightMax)
                                      ? rlpwm_pkg::BrightMax : data[6:0];
                end
                rlpwm_pkg::CfgOneDuty:  regs.one_bit_duty  = data;
                rlpwm_pkg::CfgZeroDuty: regs.zero_bit_duty = data;
                default: ;
            endcase
        endfunction

        function logic [7:0] scaled(logic [7:0] ch);
            int unsigned prod;
            prod = int'(ch) * int'(regs.bright_pct);
            return 8'(prod / int'(rlpwm_pkg::BrightMax));
        endfunction

        // expand one LED word into its duty slots
        function void note_led(rlpwm_pkg::in_word_t w);
            logic [23:0] color;
            rlpwm_pkg::out_word_t slot;
            int          gap;
            if (regs.output_enable) begin
                color = {scaled(w.led_color[23:16]), scaled(w.led_color[15:8]),
                         scaled(w.led_color[7:0])};
            end else begin
                color = '0;
            end
            gap = w.final_led ? rlpwm_pkg::GapSlots : 0;
            for (int i = 0; i < rlpwm_pkg::SlotsPerLed; i++) begin
                slot.duty_value = color[23] ? regs.one_bit_duty : regs.zero_bit_duty;
                slot.in_trailer = 1'b0;
                slot.run_end    = (i == rlpwm_pkg::SlotsPerLed - 1) && (gap == 0);
                slots_due.push_back(slot);
                color = color << 1;
            end
            // latch gap
            for (int i = 0; i < gap; i++) begin
                slot.duty_value = '0;
                slot.in_trailer = 1'b1;
                slot.run_end    = (i == gap - 1);
                slots_due.push_back(slot);
            end
            leds++;
            if (w.final_led) frames++;
        endfunction

        function void check_slot(rlpwm_pkg::out_word_t got);
            rlpwm_pkg::out_word_t exp_slot;
            if (slots_due.size() == 0) begin
                $display("%0t: unexpected slot duty=%0d trailer=%0b end=%0b",
                         $time, got.duty_value, got.in_trailer, got.run_end);
                errors++;
                return;
            end
            exp_slot = slots_due.pop_front();
            if (got.duty_value !== exp_slot.duty_value) begin
                $display("%0t: duty_value expected %0d actual %0d",
                         $time, exp_slot.duty_value, got.duty_value);
                errors++;
            end
            if (got.in_trailer !== exp_slot.in_trailer) begin
                $display("%0t: in_trailer expected %0b actual %0b",
                         $time, exp_slot.in_trailer, got.in_trailer);
                errors++;
            end
            if (got.run_end !== exp_slot.run_end) begin
                $display("%0t: run_end expected %0b actual %0b",
                         $time, exp_slot.run_end, got.run_end);
                errors++;
            end
            if (got === exp_slot) slots_ok++;
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    rlpwm_pkg::in_word_t  s_word    = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    rlpwm_pkg::out_word_t m_word;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [1:0]           cfg_index = rlpwm_pkg::CfgOutputEnable;
    logic [15:0]          cfg_wdata = '0;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req   = 1'b0;

    slot_scoreboard sb = new();

    rgb_led_pwm_slot_encoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_word    (s_word),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_word    (m_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #(ClkHalf) aclk = 1'b1;
        #(ClkHalf) aclk = 1'b0;
    end

    // watch both handshakes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_led(s_word);
            if (m_valid && m_ready) sb.check_slot(m_word);
        end
    end

    // output side back-pressure: random bursts, plus one long hold on request
    initial begin : rx_side
        int n;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LongHoldCyc) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 7);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // offer one LED word, maybe after an idle burst; valid stays high afterwards
    task automatic send_led(input logic [23:0] color, input logic final_led);
        int n;
        if (tx_idle_on && $urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_word.led_color <= color;
        s_word.final_led <= final_led;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid, wait for every slot, then let the pipeline settle;
    // the first edge lets the monitor log the word accepted just before
    task automatic drain_slots();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.slots_due.size() != 0) @(posedge aclk);
        repeat (SettleCyc) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_duty();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // new random register setting; full 16-bit data exercises the ignored bits
    task automatic shuffle_regs();
        logic [15:0] en_data;
        logic [15:0] br_data;
        en_data = 16'($urandom);
        en_data[0] = ($urandom_range(0, 7) != 0);
        br_data = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100));
        write_reg(rlpwm_pkg::CfgOutputEnable, en_data);
        write_reg(rlpwm_pkg::CfgBrightness, br_data);
        write_reg(rlpwm_pkg::CfgOneDuty, pick_duty());
        write_reg(rlpwm_pkg::CfgZeroDuty, pick_duty());
    endtask

    function automatic logic [23:0] pick_color();
        logic [23:0] c;
        c = 24'($urandom);
        // sometimes pin channels to their extremes
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 7))
                0:       c[8*k +: 8] = 8'h00;
                1:       c[8*k +: 8] = 8'hFF;
                default: ;
            endcase
        end
        return c;
    endfunction

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // output disabled after reset: all black at reset duties
        send_led(24'hFFFFFF, 1'b0);
        send_led(24'h123456, 1'b1);
        drain_slots();

        // full brightness, reset duties
        write_reg(rlpwm_pkg::CfgOutputEnable, 16'h0001);
        write_reg(rlpwm_pkg::CfgBrightness, 16'd100);
        send_led(24'hFFFFFF, 1'b0);
        send_led(24'h000000, 1'b0);
        send_led(24'h800001, 1'b0);
        send_led(24'h5AA5C3, 1'b1);
        drain_slots();

        // brightness writes above 100 clip to 100
        write_reg(rlpwm_pkg::CfgBrightness, 16'hFFFF);
        send_led(24'hFFFFFF, 1'b1);
        drain_slots();
        write_reg(rlpwm_pkg::CfgBrightness, 16'h0065);
        send_led(24'h7F80FE, 1'b0);
        drain_slots();

        // tiny and zero brightness
        write_reg(rlpwm_pkg::CfgBrightness, 16'd1);
        send_led(24'hFFFFFF, 1'b0);
        send_led(24'h646432, 1'b0);
        drain_slots();
        write_reg(rlpwm_pkg::CfgBrightness, 16'd0);
        send_led(24'hFFFFFF, 1'b1);
        drain_slots();

        // duty extremes, both ways round
        write_reg(rlpwm_pkg::CfgBrightness, 16'd50);
        write_reg(rlpwm_pkg::CfgOneDuty, 16'hFFFF);
        write_reg(rlpwm_pkg::CfgZeroDuty, 16'h0000);
        send_led(24'hFFC801, 1'b0);
        send_led(24'hAA55FF, 1'b1);
        drain_slots();
        write_reg(rlpwm_pkg::CfgOneDuty, 16'h0000);
        write_reg(rlpwm_pkg::CfgZeroDuty, 16'hFFFF);
        send_led(24'h0F0F0F, 1'b0);
        drain_slots();

        // upper brightness bits are dropped before the clip
        write_reg(rlpwm_pkg::CfgBrightness, 16'h7FE4);
        send_led(24'h3C7E99, 1'b0);
        drain_slots();

        // enable write with bit 0 clear turns output off
        write_reg(rlpwm_pkg::CfgOutputEnable, 16'hFFFE);
        send_led(24'hFFFFFF, 1'b1);
        send_led(24'h81C3E7, 1'b0);
        drain_slots();

        // random phases; one long output hold, last phase runs without idling
        for (int ph = 0; ph < RandPhases; ph++) begin
            shuffle_regs();
            if (ph == 2) hold_req = 1'b1;
            if (ph == RandPhases - 1) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            for (int i = 0; i < LedsPerPh; i++) begin
                send_led(pick_color(), $urandom_range(0, 3) == 0);
            end
            drain_slots();
        end

        if (sb.slots_due.size() != 0) begin
            $display("%0t: %0d expected slots never arrived", $time, sb.slots_due.size());
            sb.errors++;
        end
        $display("Encoded %0d LEDs in %0d frames, %0d slots matched.",
                 sb.leds, sb.frames, sb.slots_ok);
        $display("Covered: output on/off, brightness 0..100 with clipping, duty extremes.");
        if (sb.errors == 0) begin
            $display("rgb_led_pwm_slot_encoder test passed");
        end else begin
            $display("rgb_led_pwm_slot_encoder test failed");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #(TimeLimitNs);
        $display("%0t: timeout with %0d slots outstanding", $time, sb.slots_due.size());
        $display("rgb_led_pwm_slot_encoder test failed");
        $finish;
    end

endmodule

// ===== rgb_led_pwm_slot_encoder.f =====
sv/rlpwm_pkg.sv
sv/rlpwm_scaler.sv
sv/rlpwm_slot_gen.sv
sv/rgb_led_pwm_slot_encoder.sv
dv/tb.sv
